// ----- sv/assert_macros.svh -----
// Concurrent assertion helpers, compiled out with NO_ASSERTIONS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check prop at every rising clock edge outside reset.
`define U_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond never holds outside reset.
`define U_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define U_ASSERT(label, clk, rst_n, prop, msg)
`define U_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- sv/u16u8_pkg.sv -----
package u16u8_pkg;

  localparam int unsigned CuW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned CntW = 2;
  localparam int unsigned CpW = 21;

  // Upper six bits of a code unit that mark a surrogate.
  localparam logic [5:0] SurHighTag = 6'b110110;
  localparam logic [5:0] SurLowTag = 6'b110111;

  localparam logic [CuW-1:0] OneByteMax = 16'h007F;
  localparam logic [CuW-1:0] TwoByteMax = 16'h07FF;
  localparam logic [CpW-1:0] SuppBase = 21'h010000;

  localparam logic [ByteW-1:0] Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Lead4 = 8'hF0;
  localparam logic [ByteW-1:0] ContTag = 8'h80;

  // One queued run: all bytes an item produces, plus its flags.
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                last_idx;
    logic                           str_last;
    logic                           bad;
  } run_t;

endpackage

// ----- sv/utf16le_to_utf8_transcoder_core.sv -----
// Channel   Dir  tdata                    tlast         tuser
// s_axis    in   [15:0] code_unit         string_last   -
// m_axis    out  [7:0]  out_byte          run_last      [0] string_end, [1] bad_input
//
// One result byte leaves per cycle while m_axis_tready_i is high and runs are queued; an item
// yields 0 to 4 bytes (3 for a BMP unit above 07FF, 4 for a completed surrogate pair).
// The front takes one item per cycle while the run queue (QueueDepth runs) has room.
// Reset clears the pending surrogate, the queue and the output stage; no clearing pass.
// Output stalls back up through the queue to s_axis_tready_o.
`include "assert_macros.svh"

module utf16le_to_utf8_transcoder_core
  import u16u8_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [15:0] code_unit
  input  logic        s_axis_tlast_i,  // string_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_byte
  output logic        m_axis_tlast_o,  // run_last
  output logic [1:0]  m_axis_tuser_o   // [0] string_end, [1] bad_input
);

  logic push, pop, q_full, q_empty;
  run_t push_run, q_head;

  u16u8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_unit_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .push_run_o (push_run)
  );

  u16u8_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_run_i (push_run),
    .pop_i      (pop),
    .head_o     (q_head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_end_o   (m_axis_tuser_o[0]),
    .out_bad_o   (m_axis_tuser_o[1])
  );

  `U_ASSERT(a_bad_is_single, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tdata_o == 8'h00 && m_axis_tlast_o, "error result must be a lone zero byte")
  `U_ASSERT(a_end_on_last, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tlast_o, "string end off the last byte of a run")
  `U_ASSERT(a_back_refills, clk_i, rst_ni, !q_empty && !m_axis_tvalid_o |=> m_axis_tvalid_o, "output idle while runs are queued")
  `U_ASSERT_NEVER(a_no_lost_push, clk_i, rst_ni, push && q_full, "push into a full queue")

endmodule

// ----- sv/u16u8_front.sv -----
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [CuW-1:0] in_unit_i,
  input  logic           in_last_i,
  input  logic           q_full_i,
  output logic           in_ready_o,
  output logic           push_o,
  output run_t           push_run_o
);

  logic       held_valid_q, held_valid_d;
  logic [9:0] held_bits_q, held_bits_d;
  logic       accept;
  logic       is_high, is_low;
  logic [CpW-1:0] cp;

  assign in_ready_o = !q_full_i;
  assign accept = in_valid_i && in_ready_o;
  assign is_high = (in_unit_i[15:10] == SurHighTag);
  assign is_low = (in_unit_i[15:10] == SurLowTag);
  assign cp = SuppBase + {1'b0, held_bits_q, in_unit_i[9:0]};

  always_comb begin
    held_valid_d = held_valid_q;
    held_bits_d = held_bits_q;
    push_o = 1'b0;
    push_run_o = '0;
    push_run_o.str_last = in_last_i;
    if (accept) begin
      held_valid_d = 1'b0;
      held_bits_d = '0;
      if (held_valid_q) begin
        push_o = 1'b1;
        if (!is_low) begin
          push_run_o.bad = 1'b1;
        end else begin
          push_run_o.bytes[0] = Lead4 | {5'b0, cp[20:18]};
          push_run_o.bytes[1] = ContTag | {2'b0, cp[17:12]};
          push_run_o.bytes[2] = ContTag | {2'b0, cp[11:6]};
          push_run_o.bytes[3] = ContTag | {2'b0, cp[5:0]};
          push_run_o.last_idx = CntW'(3);
        end
      end else if (is_high) begin
        if (in_last_i) begin
          // truncated pair
          push_o = 1'b1;
          push_run_o.bad = 1'b1;
        end else begin
          held_valid_d = 1'b1;
          held_bits_d = in_unit_i[9:0];
        end
      end else begin
        push_o = 1'b1;
        if (in_unit_i > TwoByteMax) begin
          push_run_o.bytes[0] = Lead3 | {4'b0, in_unit_i[15:12]};
          push_run_o.bytes[1] = ContTag | {2'b0, in_unit_i[11:6]};
          push_run_o.bytes[2] = ContTag | {2'b0, in_unit_i[5:0]};
          push_run_o.last_idx = CntW'(2);
        end else if (in_unit_i > OneByteMax) begin
          push_run_o.bytes[0] = Lead2 | {3'b0, in_unit_i[10:6]};
          push_run_o.bytes[1] = ContTag | {2'b0, in_unit_i[5:0]};
          push_run_o.last_idx = CntW'(1);
        end else begin
          push_run_o.bytes[0] = in_unit_i[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_bits_q <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_bits_q <= held_bits_d;
    end
  end

endmodule

// ----- sv/u16u8_fifo.sv -----
module u16u8_fifo
  import u16u8_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t push_run_i,
  input  logic pop_i,
  output run_t head_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

  run_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o = (count_q == CntQW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign head_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_run_i;
    end
  end

endmodule

// ----- sv/u16u8_back.sv -----
module u16u8_back
  import u16u8_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  run_t             q_head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             out_last_o,
  output logic             out_end_o,
  output logic             out_bad_o
);

  run_t cur_q;
  logic cur_valid_q, cur_valid_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic fire, last_byte;

  assign out_valid_o = cur_valid_q;
  assign fire = cur_valid_q && out_ready_i;
  assign last_byte = (idx_q == cur_q.last_idx);
  // refill when idle, or as the final byte of the current run leaves
  assign pop_o = !q_empty_i && (!cur_valid_q || (fire && last_byte));

  assign out_byte_o = cur_q.bytes[idx_q];
  assign out_last_o = last_byte;
  assign out_end_o = last_byte && cur_q.str_last;
  assign out_bad_o = cur_q.bad;

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d = idx_q;
    if (pop_o) begin
      cur_valid_d = 1'b1;
      idx_d = '0;
    end else if (fire) begin
      if (last_byte) begin
        cur_valid_d = 1'b0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_head_i;
    end
  end

endmodule
